// ===== hw/rtl/ostl_pkg.sv =====
// ----------------------------------------------------------------------------
// ostl_pkg
// Shared constants, codes and types for the open slot table with LRU aging.
// ----------------------------------------------------------------------------
`default_nettype none

package ostl_pkg;

   localparam int SLOTS     = 12;
   localparam int PINNED    = 2;
   localparam int AGE_WIDTH = 16;
   localparam int SLOT_W    = 4;
   localparam int STATUS_W  = 3;
   localparam int NAME_W    = 64;
   localparam int CSR_IDX_W = 2;

   // request kinds
   localparam logic REQ_OPEN  = 1'b0;
   localparam logic REQ_CLOSE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_HIT    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ALLOC  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EVICT  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_CLOSED = 3'd3;
   localparam logic [STATUS_W-1:0] ST_PINNED = 3'd4;
   localparam logic [STATUS_W-1:0] ST_BAD    = 3'd5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REL_HI  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REL_LO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR_HI = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTR_LO = 2'd3;

   typedef logic [AGE_WIDTH-1:0] age_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;     // latch the request
      logic decide;   // register the lookup decision
      logic commit;   // apply table update, emit result
   } ostl_cmd_type;

endpackage

`default_nettype wire

// ===== hw/rtl/ostl_ctrl.sv =====
// ----------------------------------------------------------------------------
// ostl_ctrl
// Request sequencer: accept, decide, commit. Accepts the next request while
// the current one commits.
// ----------------------------------------------------------------------------
`default_nettype none

module ostl_ctrl import ostl_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output ostl_cmd_type      cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_DECIDE = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       accept;

   // nothing is taken while reset is held
   assign busy   = (state_ff == S_DECIDE) || reset;
   assign accept = start && !busy;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   state_in = accept ? S_DECIDE : S_IDLE;
         S_DECIDE: state_in = S_COMMIT;
         S_COMMIT: state_in = accept ? S_DECIDE : S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign cmd.load   = accept;
   assign cmd.decide = (state_ff == S_DECIDE);
   assign cmd.commit = (state_ff == S_COMMIT);

   a_accept_decides: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.decide)
      else $error("accepted request not followed by decide");
   a_decide_commits: assert property (@(posedge clock) disable iff (reset)
      cmd.decide |=> cmd.commit)
      else $error("decide not followed by commit");
   a_commit_has_cause: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> $past(cmd.decide))
      else $error("commit without a decide");

endmodule

`default_nettype wire

// ===== hw/rtl/ostl_dp.sv =====
// ----------------------------------------------------------------------------
// ostl_dp
// Slot table datapath: name compare, free and oldest search, age update,
// catalog registers and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ostl_dp import ostl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ostl_cmd_type          cmd,
   input  wire logic                  req_type,
   input  wire logic [NAME_W-1:0]     req_name_hi,
   input  wire logic [NAME_W-1:0]     req_name_lo,
   input  wire logic [SLOT_W-1:0]     req_close_slot,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [NAME_W-1:0]     csr_wdata,
   output logic                       rsp_valid,
   output logic [SLOT_W-1:0]          rsp_slot_num,
   output logic [STATUS_W-1:0]        rsp_status
);

   localparam age_type AGE_MAX = '1;

   // lowest set bit
   function automatic logic [SLOT_W-1:0] first_set(input logic [SLOTS-1:0] vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (vec[i]) idx = SLOT_W'(i);
      end
      return idx;
   endfunction

   // catalog names of the pinned slots
   logic [NAME_W-1:0] cat_hi_ff [PINNED];
   logic [NAME_W-1:0] cat_lo_ff [PINNED];

   // table state
   logic [SLOTS-1:0]  used_ff;
   logic [NAME_W-1:0] name_hi_ff [SLOTS];
   logic [NAME_W-1:0] name_lo_ff [SLOTS];
   age_type           age_ff [SLOTS];

   // latched request
   logic              rtype_ff;
   logic [NAME_W-1:0] rhi_ff, rlo_ff;
   logic [SLOT_W-1:0] rcs_ff;

   // decision
   logic [SLOT_W-1:0]   dslot_ff, dslot_in;
   logic [STATUS_W-1:0] dstat_ff, dstat_in;
   logic                dopen_ff, dopen_in;
   logic                dalloc_ff, dalloc_in;
   logic                dclose_ff, dclose_in;

   logic                rsp_valid_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [STATUS_W-1:0] rsp_status_ff;

   logic [SLOTS-1:0] match_vec, free_vec, oldest_vec;
   logic             used_at_cs;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PINNED; p++) begin
            cat_hi_ff[p] <= '0;
            cat_lo_ff[p] <= '0;
         end
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REL_HI:  cat_hi_ff[0] <= csr_wdata;
            CSR_REL_LO:  cat_lo_ff[0] <= csr_wdata;
            CSR_ATTR_HI: cat_hi_ff[1] <= csr_wdata;
            CSR_ATTR_LO: cat_lo_ff[1] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rtype_ff <= req_type;
         rhi_ff   <= req_name_hi;
         rlo_ff   <= req_name_lo;
         rcs_ff   <= req_close_slot;
      end
   end

   // parallel compare over all slots and pairwise age compare over the unpinned slots
   always_comb begin
      match_vec  = '0;
      free_vec   = '0;
      oldest_vec = '0;
      used_at_cs = 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
         if (i < PINNED) begin
            match_vec[i] = used_ff[i] && cat_hi_ff[i % PINNED] == rhi_ff
                           && cat_lo_ff[i % PINNED] == rlo_ff;
         end else begin
            match_vec[i] = used_ff[i] && name_hi_ff[i] == rhi_ff
                           && name_lo_ff[i] == rlo_ff;
            free_vec[i]  = !used_ff[i];
            oldest_vec[i] = 1'b1;
            // lowest index wins ties
            for (int j = PINNED; j < SLOTS; j++) begin
               if (j < i && age_ff[j] >= age_ff[i]) oldest_vec[i] = 1'b0;
               if (j > i && age_ff[j] > age_ff[i])  oldest_vec[i] = 1'b0;
            end
         end
         if (rcs_ff == SLOT_W'(i)) used_at_cs = used_ff[i];
      end
   end

   always_comb begin
      dslot_in  = rcs_ff;
      dstat_in  = ST_BAD;
      dopen_in  = 1'b0;
      dalloc_in = 1'b0;
      dclose_in = 1'b0;
      if (rtype_ff == REQ_CLOSE) begin
         if ({1'b0, rcs_ff} < (SLOT_W+1)'(PINNED)) begin
            dstat_in = ST_PINNED;
         end else if ({1'b0, rcs_ff} >= (SLOT_W+1)'(SLOTS) || !used_at_cs) begin
            dstat_in = ST_BAD;
         end else begin
            dstat_in  = ST_CLOSED;
            dclose_in = 1'b1;
         end
      end else begin
         dopen_in = 1'b1;
         if (|match_vec) begin
            dslot_in = first_set(match_vec);
            dstat_in = ST_HIT;
         end else if (|free_vec) begin
            dslot_in  = first_set(free_vec);
            dstat_in  = ST_ALLOC;
            dalloc_in = 1'b1;
         end else begin
            dslot_in  = first_set(oldest_vec);
            dstat_in  = ST_EVICT;
            dalloc_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         dslot_ff  <= dslot_in;
         dstat_ff  <= dstat_in;
         dopen_ff  <= dopen_in;
         dalloc_ff <= dalloc_in;
         dclose_ff <= dclose_in;
      end
   end

   // table update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            used_ff[i] <= (i < PINNED);
            age_ff[i]  <= '0;
         end
      end else if (cmd.commit) begin
         for (int i = PINNED; i < SLOTS; i++) begin
            if (dopen_ff) begin
               if (dslot_ff == SLOT_W'(i)) begin
                  age_ff[i] <= '0;
               end else if (used_ff[i] && age_ff[i] != AGE_MAX) begin
                  age_ff[i] <= age_ff[i] + 1'b1;
               end
            end
            if (dslot_ff == SLOT_W'(i)) begin
               if (dalloc_ff) used_ff[i] <= 1'b1;
               if (dclose_ff) used_ff[i] <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && dalloc_ff) begin
         name_hi_ff[dslot_ff] <= rhi_ff;
         name_lo_ff[dslot_ff] <= rlo_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit;
      end
      if (cmd.commit) begin
         rsp_slot_ff   <= dslot_ff;
         rsp_status_ff <= dstat_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_slot_num = rsp_slot_ff;
   assign rsp_status   = rsp_status_ff;

   a_pinned_used: assert property (@(posedge clock) disable iff (reset)
      used_ff[0] && used_ff[1])
      else $error("pinned slot marked free");
   a_alloc_marks_used: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && dalloc_ff |=> used_ff[$past(dslot_ff)])
      else $error("allocated slot not marked used");
   a_open_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == ST_ALLOC || rsp_status_ff == ST_EVICT)
      |-> rsp_slot_ff >= SLOT_W'(PINNED) && rsp_slot_ff < SLOT_W'(SLOTS))
      else $error("allocation outside replaceable slots");

endmodule

`default_nettype wire

// ===== hw/rtl/open_slot_table_lru_core.sv =====
// ----------------------------------------------------------------------------
// open_slot_table_lru_core
// Open slot table with pinned catalog slots and LRU replacement by aging.
// ----------------------------------------------------------------------------
// The request passes the request latch, the decide registers and the result
//   registers before rsp_valid rises.
// A request is decided, then committed; the next start is taken during commit
//   (busy is high in decide and reset).
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: synchronous; slots 0 and 1 used, others free, ages and catalog
//   names zero. No clearing pass.
`default_nettype none

module open_slot_table_lru_core import ostl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_type,
   input  wire logic [NAME_W-1:0]     req_name_hi,
   input  wire logic [NAME_W-1:0]     req_name_lo,
   input  wire logic [SLOT_W-1:0]     req_close_slot,
   output logic                       rsp_valid,
   output logic [SLOT_W-1:0]          rsp_slot_num,
   output logic [STATUS_W-1:0]        rsp_status,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [NAME_W-1:0]     csr_wdata
);

   ostl_cmd_type cmd;

   ostl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   ostl_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_type),
      .req_name_hi    (req_name_hi),
      .req_name_lo    (req_name_lo),
      .req_close_slot (req_close_slot),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_slot_num   (rsp_slot_num),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the open slot table with pinned catalog slots and
// LRU replacement by aging. A predictor in the bench tracks slot occupancy,
// names and ages, and every strobed result is compared in order against it.
// Directed checks cover reset, catalog registers, fill, eviction and closes;
// random phases then mix opens from a small name pool with closes.
// ----------------------------------------------------------------------------
module tb_top import ostl_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 8;
   localparam int RESET_CYCLES   = 5;
   localparam int DRAIN_CYCLES   = 4;
   localparam int MAX_GAP        = 24;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int REPORT_LIMIT   = 10;
   localparam int POOL_SIZE      = 16;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
   } slot_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_type;
   logic [NAME_W-1:0]    req_name_hi;
   logic [NAME_W-1:0]    req_name_lo;
   logic [SLOT_W-1:0]    req_close_slot;
   logic                 rsp_valid;
   logic [SLOT_W-1:0]    rsp_slot_num;
   logic [STATUS_W-1:0]  rsp_status;
   logic                 csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [NAME_W-1:0]    csr_wdata;

   // predicted table; entries 0 and 1 hold the catalog names
   logic              tbl_used    [SLOTS];
   logic [NAME_W-1:0] tbl_name_hi [SLOTS];
   logic [NAME_W-1:0] tbl_name_lo [SLOTS];
   age_type           tbl_age     [SLOTS];

   slot_result_type   pending_results [$];
   slot_result_type   want;
   logic [NAME_W-1:0] pool_hi [POOL_SIZE];
   logic [NAME_W-1:0] pool_lo [POOL_SIZE];

   int status_tally [6];
   int fail_count;
   int checked_count;
   int sent_count;
   int csr_writes;
   int catalog_settings;
   int sender_idle_pct;
   int quiet_cycles;

   open_slot_table_lru_core u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_type       (req_type),
      .req_name_hi    (req_name_hi),
      .req_name_lo    (req_name_lo),
      .req_close_slot (req_close_slot),
      .rsp_valid      (rsp_valid),
      .rsp_slot_num   (rsp_slot_num),
      .rsp_status     (rsp_status),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Applies one request to the predicted table and returns its result.
   function automatic slot_result_type resolve_request(input logic kind,
         input logic [NAME_W-1:0] hi, input logic [NAME_W-1:0] lo,
         input logic [SLOT_W-1:0] cs);
      slot_result_type res;
      int sel;
      age_type oldest;
      res.slot = cs;
      sel = -1;
      if (kind == REQ_CLOSE) begin
         if (cs < PINNED) res.status = ST_PINNED;
         else if (cs >= SLOTS) res.status = ST_BAD;
         else if (!tbl_used[cs]) res.status = ST_BAD;
         else begin
            tbl_used[cs] = 1'b0;
            res.status = ST_CLOSED;
         end
      end else begin
         for (int i = 0; i < SLOTS; i++)
            if (sel < 0 && tbl_used[i] && tbl_name_hi[i] == hi && tbl_name_lo[i] == lo)
               sel = i;
         if (sel >= 0) begin
            res.status = ST_HIT;
         end else begin
            for (int i = PINNED; i < SLOTS; i++)
               if (sel < 0 && !tbl_used[i]) sel = i;
            if (sel >= 0) begin
               res.status = ST_ALLOC;
            end else begin
               // strictly greater keeps the lowest index on ties
               sel = PINNED;
               oldest = tbl_age[PINNED];
               for (int i = PINNED + 1; i < SLOTS; i++)
                  if (tbl_age[i] > oldest) begin
                     oldest = tbl_age[i];
                     sel = i;
                  end
               res.status = ST_EVICT;
            end
         end
         // pinned slots never age; a pinned hit still ages the others
         for (int i = PINNED; i < SLOTS; i++)
            if (tbl_used[i]) begin
               if (i == sel) tbl_age[i] = '0;
               else if (tbl_age[i] != '1) tbl_age[i] = tbl_age[i] + 1'b1;
            end
         if (res.status != ST_HIT) begin
            tbl_used[sel] = 1'b1;
            tbl_name_hi[sel] = hi;
            tbl_name_lo[sel] = lo;
            tbl_age[sel] = '0;
         end
         res.slot = sel[SLOT_W-1:0];
      end
      status_tally[res.status]++;
      return res;
   endfunction

   task automatic send_request(input logic kind, input logic [NAME_W-1:0] hi,
         input logic [NAME_W-1:0] lo, input logic [SLOT_W-1:0] cs);
      int gap;
      @(negedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_name_hi <= hi;
      req_name_lo <= lo;
      req_close_slot <= cs;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(resolve_request(kind, hi, lo, cs));
      sent_count++;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Stops issuing and waits until every result is in and the pipe is empty.
   task automatic settle_table();
      @(negedge clock);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
         input logic [NAME_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_REL_HI:  tbl_name_hi[0] = data;
         CSR_REL_LO:  tbl_name_lo[0] = data;
         CSR_ATTR_HI: tbl_name_hi[1] = data;
         CSR_ATTR_LO: tbl_name_lo[1] = data;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_catalog(input logic [NAME_W-1:0] rel_hi,
         input logic [NAME_W-1:0] rel_lo, input logic [NAME_W-1:0] attr_hi,
         input logic [NAME_W-1:0] attr_lo);
      settle_table();
      csr_write(CSR_REL_HI, rel_hi);
      csr_write(CSR_REL_LO, rel_lo);
      csr_write(CSR_ATTR_HI, attr_hi);
      csr_write(CSR_ATTR_LO, attr_lo);
      catalog_settings++;
   endtask

   // both catalog names are zero out of reset, so a zero name hits slot 0
   task automatic test_reset_defaults();
      send_request(REQ_OPEN, '0, '0, '1);
   endtask

   task automatic test_catalog_match();
      load_catalog('1, '0, '0, '1);
      send_request(REQ_OPEN, '1, '0, '0);
      send_request(REQ_OPEN, '0, '1, '1);
   endtask

   task automatic test_fill_evict_close();
      send_request(REQ_OPEN, '0, '0, 4'd0);
      send_request(REQ_OPEN, '1, '1, 4'd15);
      for (int i = 0; i < SLOTS - PINNED - 2; i++)
         send_request(REQ_OPEN, {$urandom, $urandom}, {$urandom, $urandom},
                      SLOT_W'($urandom_range(15)));
      send_request(REQ_OPEN, '1, '1, 4'd0);                         // plain hit
      send_request(REQ_OPEN, tbl_name_hi[1], tbl_name_lo[1], 4'd0); // pinned hit
      send_request(REQ_OPEN, {$urandom, $urandom}, {$urandom, $urandom}, 4'd0);
      send_request(REQ_CLOSE, '0, '0, 4'd0);
      send_request(REQ_CLOSE, '1, '1, 4'd1);
      send_request(REQ_CLOSE, '0, '1, 4'(SLOTS));
      send_request(REQ_CLOSE, '1, '0, 4'd15);
      send_request(REQ_CLOSE, '0, '0, 4'd5);
      send_request(REQ_CLOSE, '0, '0, 4'd5);                        // already free
      send_request(REQ_OPEN, {$urandom, $urandom}, {$urandom, $urandom}, 4'd5);
   endtask

   task automatic test_random_traffic(input int pct, input int count);
      int pick;
      int k;
      int used_list [$];
      logic [SLOT_W-1:0] cs;
      sender_idle_pct = pct;
      repeat (count) begin
         pick = $urandom_range(99);
         if (pick < 58) begin
            k = $urandom_range(POOL_SIZE - 1);
            send_request(REQ_OPEN, pool_hi[k], pool_lo[k], SLOT_W'($urandom_range(15)));
         end else if (pick < 66) begin
            send_request(REQ_OPEN, {$urandom, $urandom}, {$urandom, $urandom},
                         SLOT_W'($urandom_range(15)));
         end else if (pick < 72) begin
            k = $urandom_range(PINNED - 1);
            send_request(REQ_OPEN, tbl_name_hi[k], tbl_name_lo[k],
                         SLOT_W'($urandom_range(15)));
         end else begin
            used_list.delete();
            for (int i = PINNED; i < SLOTS; i++)
               if (tbl_used[i]) used_list.push_back(i);
            if (used_list.size() != 0 && $urandom_range(3) != 0)
               cs = SLOT_W'(used_list[$urandom_range(used_list.size() - 1)]);
            else
               cs = SLOT_W'($urandom_range(15));
            send_request(REQ_CLOSE, {$urandom, $urandom}, {$urandom, $urandom}, cs);
         end
      end
      sender_idle_pct = 0;
   endtask

   // result checker: the receiver cannot stall, so every strobe is a transfer
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("%0t: unexpected result slot %0d status %0d", $time,
                        rsp_slot_num, rsp_status);
         end else begin
            want = pending_results.pop_front();
            checked_count++;
            if (rsp_slot_num !== want.slot || rsp_status !== want.status) begin
               fail_count++;
               if (fail_count <= REPORT_LIMIT)
                  $display("%0t: mismatch slot exp %0d got %0d, status exp %0d got %0d",
                           $time, want.slot, rsp_slot_num, want.status, rsp_status);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_OPEN;
      req_name_hi = '0;
      req_name_lo = '0;
      req_close_slot = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_REL_HI;
      csr_wdata = '0;
      quiet_cycles = 0;
      fail_count = 0;
      checked_count = 0;
      sent_count = 0;
      csr_writes = 0;
      catalog_settings = 0;
      sender_idle_pct = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      for (int i = 0; i < SLOTS; i++) begin
         tbl_used[i] = (i < PINNED);
         tbl_name_hi[i] = '0;
         tbl_name_lo[i] = '0;
         tbl_age[i] = '0;
      end
      // some pool names share a half so partial matches get exercised
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_hi[i] = {$urandom, $urandom};
         pool_lo[i] = {$urandom, $urandom};
      end
      for (int i = 1; i < 4; i++) pool_hi[i] = pool_hi[0];
      for (int i = 5; i < 8; i++) pool_lo[i] = pool_lo[4];

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_catalog_match();
      test_fill_evict_close();

      load_catalog('0, '0, '1, '1);
      test_random_traffic(0, 360);
      load_catalog(pool_hi[0], pool_lo[0], pool_hi[5], pool_lo[5]);
      test_random_traffic(77, 360);
      // receiver stalls do not apply here; the last phase idles the sender only
      load_catalog({$urandom, $urandom}, {$urandom, $urandom},
                   {$urandom, $urandom}, {$urandom, $urandom});
      test_random_traffic(32, 360);
      settle_table();

      $display("%0d requests, %0d results checked: %0d hits, %0d allocs, %0d evictions",
               sent_count, checked_count, status_tally[ST_HIT], status_tally[ST_ALLOC],
               status_tally[ST_EVICT]);
      $display("%0d closes, %0d pinned rejects, %0d bad closes; %0d catalog settings (%0d writes)",
               status_tally[ST_CLOSED], status_tally[ST_PINNED], status_tally[ST_BAD],
               catalog_settings, csr_writes);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d failures, %0d results missing", fail_count,
                  pending_results.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ostl_pkg.sv
hw/rtl/ostl_ctrl.sv
hw/rtl/ostl_dp.sv
hw/rtl/open_slot_table_lru_core.sv
sim/tb_top.sv
